// File: src/lc2k_pkg.sv
// Shared constants, opcodes and types for the LC-2K instruction step unit.
// Used by the step unit and the register file; depends on nothing.
package lc2k_pkg;

  localparam int XLEN      = 32;
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int PC_W      = 16;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 136;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  // Register file write request
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

// File: src/lc2k_instruction_step_unit.sv
// LC-2K instruction step unit: loads program words and executes one instruction
// per step item. Depends on lc2k_pkg, lc2k_ram and lc2k_regfile.
// Path to the output register: a load item or a step after halt goes straight to FINISH,
// a step passes FETCH, EXEC and FINISH, and lw adds LOAD after EXEC. One item is in work
// at a time and the input reopens the cycle after the result is registered. The states
// follow the main memory read port (fetch, then lw data) and the register file read.
// Reset clears pc, halt flag, executed count and register valid bits, not main memory.
module lc2k_instruction_step_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] load_address, [47:16] load_data
  input  logic [47:0]  s_tdata,
  // [0] kind
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] pc_now, [16] halted, [17] reg_written, [20:18] reg_index,
  // [52:21] reg_value, [53] mem_written, [69:54] mem_address,
  // [101:70] mem_value, [133:102] executed_count, [135:134] zero
  output logic [135:0] m_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_LOAD,
    ST_FINISH
  } state_t;

  // Write fields of one result, built up while the item is in work
  typedef struct packed {
    logic                              reg_written;
    logic [2:0]                        reg_index;
    logic [lc2k_pkg::XLEN-1:0]         reg_value;
    logic                              mem_written;
    logic [lc2k_pkg::PC_W-1:0]         mem_address;
    logic [lc2k_pkg::XLEN-1:0]         mem_value;
  } result_t;

  state_t                          state;
  logic [lc2k_pkg::MEM_AW-1:0]     pc;
  logic                            halted;
  logic [lc2k_pkg::XLEN-1:0]       count;
  logic [lc2k_pkg::XLEN-1:0]       instr;
  result_t                         res;
  logic                            out_valid;
  logic [lc2k_pkg::OUT_W-1:0]      out_data;

  // Memory port and decode signals
  logic                            s_accept;
  logic                            mem_we;
  logic [lc2k_pkg::MEM_AW-1:0]     mem_wa;
  logic [lc2k_pkg::XLEN-1:0]       mem_wd;
  logic                            mem_re;
  logic [lc2k_pkg::MEM_AW-1:0]     mem_ra;
  logic [lc2k_pkg::XLEN-1:0]       mem_rdata;
  lc2k_pkg::rf_wr_t                rf_wr;
  logic                            rf_re;
  logic [lc2k_pkg::XLEN-1:0]       a_val;
  logic [lc2k_pkg::XLEN-1:0]       b_val;
  lc2k_pkg::opcode_t               op;
  logic [lc2k_pkg::REG_AW-1:0]     ra_idx;
  logic [lc2k_pkg::REG_AW-1:0]     rb_idx;
  logic [lc2k_pkg::XLEN-1:0]       off32;
  logic [lc2k_pkg::XLEN-1:0]       addr_sum;
  logic [lc2k_pkg::XLEN-1:0]       br_sum;
  logic [lc2k_pkg::XLEN-1:0]       link;
  logic [lc2k_pkg::MEM_AW-1:0]     seq_pc;
  logic [lc2k_pkg::MEM_AW-1:0]     exec_pc;
  logic [lc2k_pkg::XLEN-1:0]       count_next;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Decode from the held instruction word
  assign op     = lc2k_pkg::opcode_t'(instr[24:22]);
  assign ra_idx = instr[21:19];
  assign rb_idx = instr[18:16];
  assign off32  = {{16{instr[15]}}, instr[15:0]};

  assign addr_sum   = a_val + off32;
  assign br_sum     = lc2k_pkg::XLEN'(pc) + lc2k_pkg::XLEN'(1) + off32;
  assign link       = lc2k_pkg::XLEN'(pc) + lc2k_pkg::XLEN'(1);
  assign seq_pc     = link[lc2k_pkg::MEM_AW-1:0];
  assign count_next = (count == '1) ? count : count + lc2k_pkg::XLEN'(1);

  // Next pc for everything finished in the execute cycle
  always_comb begin
    exec_pc = seq_pc;
    case (op)
      lc2k_pkg::OP_BEQ: begin
        if (a_val == b_val) begin
          exec_pc = br_sum[lc2k_pkg::MEM_AW-1:0];
        end
      end
      lc2k_pkg::OP_JALR: begin
        // regA is read after the link write, so equal indices land on pc + 1
        exec_pc = (ra_idx == rb_idx) ? seq_pc : a_val[lc2k_pkg::MEM_AW-1:0];
      end
      default: exec_pc = seq_pc;
    endcase
  end

  // Memory and register file port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = pc;
    rf_wr  = '0;
    rf_re  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (!s_tuser[0]) begin
            mem_we = 1'b1;
            mem_wa = s_tdata[lc2k_pkg::MEM_AW-1:0];
            mem_wd = s_tdata[47:16];
          end else if (!halted) begin
            mem_re = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        rf_re = 1'b1;
      end
      ST_EXEC: begin
        case (op)
          lc2k_pkg::OP_ADD: begin
            rf_wr = '{en: 1'b1, idx: instr[2:0], data: a_val + b_val};
          end
          lc2k_pkg::OP_NOR: begin
            rf_wr = '{en: 1'b1, idx: instr[2:0], data: ~(a_val | b_val)};
          end
          lc2k_pkg::OP_LW: begin
            mem_re = 1'b1;
            mem_ra = addr_sum[lc2k_pkg::MEM_AW-1:0];
          end
          lc2k_pkg::OP_SW: begin
            mem_we = 1'b1;
            mem_wa = addr_sum[lc2k_pkg::MEM_AW-1:0];
            mem_wd = b_val;
          end
          lc2k_pkg::OP_JALR: begin
            rf_wr = '{en: 1'b1, idx: rb_idx, data: link};
          end
          default: rf_wr = '0;
        endcase
      end
      ST_LOAD: begin
        rf_wr = '{en: 1'b1, idx: rb_idx, data: mem_rdata};
      end
      default: rf_wr = '0;
    endcase
  end

  lc2k_ram #(.WIDTH(lc2k_pkg::XLEN), .DEPTH(lc2k_pkg::MEM_WORDS)) u_main_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rdata)
  );

  // Register indices come straight from the fetched word
  lc2k_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (rf_wr),
    .rd_en     (rf_re),
    .rd_idx_a  (mem_rdata[21:19]),
    .rd_idx_b  (mem_rdata[18:16]),
    .rd_data_a (a_val),
    .rd_data_b (b_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      halted    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once the transfer completes, unless a new one replaces it
      if (out_valid && m_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (!s_tuser[0]) begin
              res   <= '{reg_written: 1'b0, reg_index: '0, reg_value: '0,
                         mem_written: 1'b1, mem_address: lc2k_pkg::PC_W'(mem_wa),
                         mem_value: mem_wd};
              state <= ST_FINISH;
            end else if (halted) begin
              res   <= '0;
              state <= ST_FINISH;
            end else begin
              res   <= '0;
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          instr <= mem_rdata;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          res <= '{reg_written: rf_wr.en,
                   reg_index:   rf_wr.en ? rf_wr.idx : '0,
                   reg_value:   rf_wr.en ? rf_wr.data : '0,
                   mem_written: mem_we,
                   mem_address: lc2k_pkg::PC_W'(mem_wa),
                   mem_value:   mem_wd};
          if (op == lc2k_pkg::OP_LW) begin
            state <= ST_LOAD;
          end else begin
            pc    <= exec_pc;
            count <= count_next;
            if (op == lc2k_pkg::OP_HALT) begin
              halted <= 1'b1;
            end
            state <= ST_FINISH;
          end
        end
        ST_LOAD: begin
          res   <= '{reg_written: 1'b1, reg_index: rf_wr.idx, reg_value: rf_wr.data,
                     mem_written: 1'b0, mem_address: '0, mem_value: '0};
          pc    <= seq_pc;
          count <= count_next;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid || m_tready) begin
            out_data  <= {2'b00, count, res.mem_value, res.mem_address, res.mem_written,
                          res.reg_value, res.reg_index, res.reg_written, halted,
                          lc2k_pkg::PC_W'(pc)};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Halt is sticky until reset
  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag cleared without reset");

  // No item writes both a register and memory
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !(m_tdata[17] && m_tdata[53]))
    else $error("result reports both a register and a memory write");

  // Executed count only ever advances by one
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> count == $past(count) + lc2k_pkg::XLEN'(1))
    else $error("executed count moved by other than one");

endmodule

// File: src/lc2k_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module lc2k_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/lc2k_regfile.sv
// Eight-entry register file: two RAM copies give two read ports, and per-entry
// valid bits make unwritten registers read as zero. Depends on lc2k_pkg, lc2k_ram.
module lc2k_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  lc2k_pkg::rf_wr_t              wr,
  input  logic                          rd_en,
  input  logic [lc2k_pkg::REG_AW-1:0]   rd_idx_a,
  input  logic [lc2k_pkg::REG_AW-1:0]   rd_idx_b,
  output logic [lc2k_pkg::XLEN-1:0]     rd_data_a,
  output logic [lc2k_pkg::XLEN-1:0]     rd_data_b
);

  logic [lc2k_pkg::REG_COUNT-1:0] valid;
  logic                           ok_a;
  logic                           ok_b;
  logic [lc2k_pkg::XLEN-1:0]      raw_a;
  logic [lc2k_pkg::XLEN-1:0]      raw_b;

  lc2k_ram #(.WIDTH(lc2k_pkg::XLEN), .DEPTH(lc2k_pkg::REG_COUNT)) u_bank_a (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.idx),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_a),
    .rd_data (raw_a)
  );

  lc2k_ram #(.WIDTH(lc2k_pkg::XLEN), .DEPTH(lc2k_pkg::REG_COUNT)) u_bank_b (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.idx),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_b),
    .rd_data (raw_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ok_a  <= 1'b0;
      ok_b  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        ok_a <= valid[rd_idx_a];
        ok_b <= valid[rd_idx_b];
      end
    end
  end

  // Never-written registers read as zero
  assign rd_data_a = ok_a ? raw_a : '0;
  assign rd_data_b = ok_b ? raw_b : '0;

endmodule

// File: verif/lc2k_tb_pkg.sv
// Item kind codes shared by the LC-2K step unit testbench and its checker.
// Depends on nothing.
package lc2k_tb_pkg;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } item_kind_t;

endpackage

// File: verif/lc2k_step_checker.sv
// Scoreboard for the LC-2K step unit: tracks the machine state per input transfer,
// predicts each report and compares it with the output channel.
// Depends on lc2k_pkg and lc2k_tb_pkg.
module lc2k_step_checker
  import lc2k_pkg::*;
  import lc2k_tb_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [47:0]                      s_tdata,
  input  logic [0:0]                       s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [135:0]                     m_tdata,
  output int                               mismatches,
  output int                               reports_owed,
  output logic [PC_W-1:0]                  pc_state,
  output logic                             halt_state,
  output logic [REG_COUNT-1:0][XLEN-1:0]   reg_state,
  output logic [XLEN-1:0]                  word_at_pc
);
  timeunit 1ns;
  timeprecision 1ps;

  // Laid out as on m_tdata, highest field first
  typedef struct packed {
    logic [XLEN-1:0]   executed;
    logic [XLEN-1:0]   mem_value;
    logic [MEM_AW-1:0] mem_address;
    logic              mem_written;
    logic [XLEN-1:0]   reg_value;
    logic [REG_AW-1:0] reg_index;
    logic              reg_written;
    logic              halted;
    logic [PC_W-1:0]   pc_now;
  } step_report_t;

  logic [XLEN-1:0] mem_img [0:MEM_WORDS-1];
  logic [XLEN-1:0] executed_q;
  step_report_t    step_reports [$];

  assign word_at_pc = mem_img[pc_state];

  task automatic advance_machine(input item_kind_t kind, input logic [MEM_AW-1:0] addr,
                                 input logic [XLEN-1:0] data, output step_report_t rep);
    logic [XLEN-1:0]   word;
    opcode_t           op;
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [15:0]       off;
    logic [MEM_AW-1:0] ea;
    logic [PC_W-1:0]   next_pc;
    rep = '0;
    if (kind == KIND_LOAD) begin
      mem_img[addr]   = data;
      rep.mem_written = 1'b1;
      rep.mem_address = addr;
      rep.mem_value   = data;
    end else if (!halt_state) begin
      word    = mem_img[pc_state];
      op      = opcode_t'(word[24:22]);
      ra      = word[21:19];
      rb      = word[18:16];
      off     = word[15:0];
      // signed register plus signed offset, reduced mod the memory depth
      ea      = reg_state[ra][MEM_AW-1:0] + off;
      next_pc = pc_state + 16'd1;
      case (op)
        OP_ADD: begin
          rep.reg_written = 1'b1;
          rep.reg_index   = off[2:0];
          rep.reg_value   = reg_state[ra] + reg_state[rb];
        end
        OP_NOR: begin
          rep.reg_written = 1'b1;
          rep.reg_index   = off[2:0];
          rep.reg_value   = ~(reg_state[ra] | reg_state[rb]);
        end
        OP_LW: begin
          rep.reg_written = 1'b1;
          rep.reg_index   = rb;
          rep.reg_value   = mem_img[ea];
        end
        OP_SW: begin
          rep.mem_written = 1'b1;
          rep.mem_address = ea;
          rep.mem_value   = reg_state[rb];
          mem_img[ea]     = reg_state[rb];
        end
        OP_BEQ: begin
          if (reg_state[ra] == reg_state[rb]) next_pc = pc_state + 16'd1 + off;
        end
        OP_JALR: begin
          // link is written first, so the target reads it when A equals B
          rep.reg_written = 1'b1;
          rep.reg_index   = rb;
          rep.reg_value   = {16'd0, pc_state} + 32'd1;
          reg_state[rb]   = rep.reg_value;
          next_pc         = reg_state[ra][PC_W-1:0];
        end
        OP_HALT: halt_state = 1'b1;
        default: ;
      endcase
      if (rep.reg_written) reg_state[rep.reg_index] = rep.reg_value;
      pc_state = next_pc;
      if (executed_q != '1) executed_q++;
    end
    rep.pc_now   = pc_state;
    rep.halted   = halt_state;
    rep.executed = executed_q;
  endtask

  task automatic check_field(input string name, input logic [XLEN-1:0] want,
                             input logic [XLEN-1:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    step_report_t want;
    step_report_t seen;
    if (rst) begin
      pc_state     = '0;
      halt_state   = 1'b0;
      reg_state    = '0;
      executed_q   = '0;
      mismatches   = 0;
      reports_owed = 0;
      step_reports.delete();
    end else begin
      // retire the oldest report before queueing a new one
      if (m_tvalid && m_tready) begin
        seen = step_report_t'(m_tdata[133:0]);
        if (step_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report expected none, got %h", $time, m_tdata);
        end else begin
          want = step_reports.pop_front();
          check_field("pc_now", XLEN'(want.pc_now), XLEN'(seen.pc_now));
          check_field("halted", XLEN'(want.halted), XLEN'(seen.halted));
          check_field("reg_written", XLEN'(want.reg_written), XLEN'(seen.reg_written));
          check_field("reg_index", XLEN'(want.reg_index), XLEN'(seen.reg_index));
          check_field("reg_value", want.reg_value, seen.reg_value);
          check_field("mem_written", XLEN'(want.mem_written), XLEN'(seen.mem_written));
          check_field("mem_address", XLEN'(want.mem_address), XLEN'(seen.mem_address));
          check_field("mem_value", want.mem_value, seen.mem_value);
          check_field("executed_count", want.executed, seen.executed);
          check_field("pad bits", '0, XLEN'(m_tdata[135:134]));
        end
      end
      if (s_tvalid && s_tready) begin
        advance_machine(item_kind_t'(s_tuser), s_tdata[15:0], s_tdata[47:16], want);
        step_reports.push_back(want);
      end
      reports_owed = step_reports.size();
    end
  end

endmodule

// File: verif/tb.sv
// Top of the LC-2K step unit testbench: clock, reset, program stimulus and verdict.
// Depends on lc2k_pkg, lc2k_tb_pkg, lc2k_step_checker and the unit itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lc2k_pkg::*;
  import lc2k_tb_pkg::*;

  localparam int ITEMS       = 1950;
  localparam int QUIET_TAIL  = 150;
  localparam int LONG_STALL  = 200;
  localparam int STALL_AT    = 600;
  localparam int DRAIN_AT    = 1200;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;

  int                             mismatches;
  int                             reports_owed;
  logic [PC_W-1:0]                pc_state;
  logic                           halt_state;
  logic [REG_COUNT-1:0][XLEN-1:0] reg_state;
  logic [XLEN-1:0]                word_at_pc;

  // Words the stimulus has made valid in memory; nothing else is ever fetched
  // or read by lw.
  bit mem_loaded [0:MEM_WORDS-1];
  int items_sent;
  bit quiet;
  bit stall_request;

  lc2k_instruction_step_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lc2k_step_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .reports_owed (reports_owed),
    .pc_state     (pc_state),
    .halt_state   (halt_state),
    .reg_state    (reg_state),
    .word_at_pc   (word_at_pc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous cap: several times the slowest legal run
  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [XLEN-1:0] make_word(opcode_t op, logic [2:0] ra, logic [2:0] rb,
                                                logic [15:0] off, logic [6:0] hi);
    return {hi, op, ra, rb, off};
  endfunction

  // Any instruction but halt, which would freeze the machine for the rest of the run
  function automatic logic [XLEN-1:0] random_word();
    opcode_t     op;
    logic [15:0] off;
    op = opcode_t'($urandom_range(0, 7));
    if (op == OP_HALT) op = OP_BEQ;
    case ($urandom_range(0, 5))
      0: off = 16'($urandom_range(0, 16) - 8);
      1: off = 16'h7FFF;
      2: off = 16'h8000;
      3: off = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: off = 16'($urandom());
    endcase
    return make_word(op, 3'($urandom()), 3'($urandom()), off, 7'($urandom()));
  endfunction

  // Offer one item and hold it until the transfer; drop valid on that edge
  task automatic send(input item_kind_t kind, input logic [15:0] addr,
                      input logic [31:0] data);
    @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {data, addr};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    if (kind == KIND_LOAD) mem_loaded[addr] = 1'b1;
    items_sent++;
  endtask

  // Random sender gap, then wait for the falling edge so the predicted state has settled
  task automatic pace();
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 11)) @(posedge clk);
    @(negedge clk);
  endtask

  // Step the instruction at pc; supply its lw data first if that word is still unset
  task automatic run_step();
    logic [31:0] w;
    logic [15:0] ea;
    pace();
    w  = word_at_pc;
    ea = reg_state[w[21:19]][15:0] + w[15:0];
    if (opcode_t'(w[24:22]) == OP_LW && !mem_loaded[ea]) begin
      send(KIND_LOAD, ea, $urandom());
      pace();
    end
    if (opcode_t'(w[24:22]) == OP_SW) mem_loaded[ea] = 1'b1;
    // address and data of a step transfer are don't-care: fill with noise
    send(KIND_STEP, 16'($urandom()), $urandom());
  endtask

  // Place a word at the current pc, then execute it
  task automatic run_word(input logic [31:0] w);
    pace();
    send(KIND_LOAD, pc_state, w);
    run_step();
  endtask

  // Receiver: random back-pressure bursts, one long hold-off on request,
  // always ready in the quiet tail
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (stall_request) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    bit stall_done;
    bit drain_done;
    int pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed program: wrap of a negative data address, extreme data word
    pace();
    send(KIND_LOAD, 16'hFFFF, 32'h8000_0000);
    run_word(make_word(OP_LW, 3'd0, 3'd1, 16'hFFFF, 7'd0));
    // add into register zero, destination from offset bits 2..0 only
    run_word(make_word(OP_ADD, 3'd1, 3'd0, 16'h8000, 7'd0));
    // nor into r7 with an all-ones offset
    run_word(make_word(OP_NOR, 3'd0, 3'd0, 16'hFFFF, 7'd0));
    // store with every unused high bit set
    run_word(make_word(OP_SW, 3'd0, 3'd7, 16'h7FFF, 7'h7F));
    // fetch 65535 into r2, then jump to the top of memory
    pace();
    send(KIND_LOAD, 16'd200, 32'h0000_FFFF);
    run_word(make_word(OP_LW, 3'd3, 3'd2, 16'd200, 7'd0));
    run_word(make_word(OP_JALR, 3'd2, 3'd4, 16'd0, 7'd0));
    // jalr with A equal to B at the last word: link of a full memory depth, wrap to 0
    run_word(make_word(OP_JALR, 3'd5, 3'd5, 16'd0, 7'd0));
    // branch taken backwards, not taken, taken forward far
    run_word(make_word(OP_BEQ, 3'd3, 3'd6, 16'hFFFF, 7'd0));
    run_word(make_word(OP_BEQ, 3'd0, 3'd3, 16'd5, 7'd0));
    run_word(make_word(OP_BEQ, 3'd3, 3'd6, 16'h7FFF, 7'd0));
    run_word(make_word(OP_NOOP, 3'd7, 3'd7, 16'hFFFF, 7'h55));
    // add that overflows
    run_word(make_word(OP_ADD, 3'd7, 3'd7, 16'd6, 7'd0));

    // Random programs: mostly fresh instructions placed at pc, some re-runs of
    // code already in memory, some stray loads anywhere
    while (items_sent < ITEMS - 8) begin
      if (items_sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (!stall_done && items_sent >= STALL_AT) begin
        stall_request = 1'b1;
        stall_done    = 1'b1;
      end
      if (!drain_done && items_sent >= DRAIN_AT) begin
        // hold the sender until every report is back
        @(negedge clk);
        wait (reports_owed == 0);
        drain_done = 1'b1;
      end
      @(negedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        pace();
        send(KIND_LOAD, 16'($urandom()), $urandom());
      end else if (pick < 35 && mem_loaded[pc_state] &&
                   opcode_t'(word_at_pc[24:22]) != OP_HALT) begin
        run_step();
      end else begin
        run_word(random_word());
      end
    end

    // Halt, then steps that must change nothing and loads that still land
    run_word(make_word(OP_HALT, 3'($urandom()), 3'($urandom()), 16'($urandom()), 7'd0));
    repeat (3) run_word(random_word());

    @(negedge clk);
    wait (reports_owed == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
